// ===== design/qsd_pkg.sv =====
// Package for the quadrature step decoder: request and result structs,
// pin, phase and report codes, the phase walk function and default constants.
// No dependencies.
`default_nettype none

package qsd_pkg;

    // Field widths fixed by the interface
    localparam int TIMESTAMP_W   = 32;
    localparam int TIMEOUT_W     = 32;
    localparam int TIME_W_DEF    = 32;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;

    // Request kind
    typedef enum logic {
        KIND_PIN  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    // Pin pair levels
    typedef enum logic [1:0] {
        PIN_NN = 2'd0,
        PIN_NP = 2'd1,
        PIN_PN = 2'd2,
        PIN_PP = 2'd3
    } pins_t;

    // Decoder walk phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_B0   = 3'd1,
        PH_B1   = 3'd2,
        PH_C0   = 3'd3,
        PH_C1   = 3'd4,
        PH_D0   = 3'd5,
        PH_D1   = 3'd6,
        PH_UNK  = 3'd7
    } phase_t;

    // Result reports
    typedef enum logic [2:0] {
        REP_NONE  = 3'd0,
        REP_CW    = 3'd1,
        REP_CCW   = 3'd2,
        REP_UNK   = 3'd3,
        REP_CLEAR = 3'd4
    } report_t;

    typedef struct packed {
        logic                   kind;
        logic [1:0]             pins;
        logic [TIMESTAMP_W-1:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0] report;
        logic [2:0] phase;
    } out_item_t;

    // Phase after a pin event; PP always returns to idle
    function automatic phase_t next_phase(input phase_t cur, input pins_t pins);
        phase_t nxt;
        nxt = cur;
        if (pins == PIN_PP) begin
            nxt = PH_IDLE;
        end else begin
            unique case (cur)
                PH_IDLE: begin
                    case (pins)
                        PIN_PN:  nxt = PH_B0;
                        PIN_NP:  nxt = PH_B1;
                        default: nxt = PH_UNK;
                    endcase
                end
                PH_B0: begin
                    case (pins)
                        PIN_NN:  nxt = PH_C0;
                        PIN_NP:  nxt = PH_UNK;
                        default: nxt = PH_B0;
                    endcase
                end
                PH_B1: begin
                    case (pins)
                        PIN_NN:  nxt = PH_C1;
                        PIN_PN:  nxt = PH_UNK;
                        default: nxt = PH_B1;
                    endcase
                end
                PH_C0:   nxt = (pins == PIN_NP) ? PH_D0 : PH_C0;
                PH_C1:   nxt = (pins == PIN_PN) ? PH_D1 : PH_C1;
                PH_D0:   nxt = (pins == PIN_PN) ? PH_UNK : PH_D0;
                PH_D1:   nxt = (pins == PIN_NP) ? PH_UNK : PH_D1;
                PH_UNK:  nxt = PH_UNK;
                default: nxt = PH_UNK;
            endcase
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== design/qsd_in_stage.sv =====
// Input register of the quadrature step decoder: holds one request until
// the decode stage takes it. Depends on qsd_pkg.
`default_nettype none

module qsd_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qsd_pkg::in_item_t s_data,
    input  wire logic              advance,
    output logic                   hold_valid,
    output qsd_pkg::in_item_t      hold_data
);
    import qsd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // Take a new request whenever the held one is empty or leaving
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/qsd_core.sv =====
// Decode logic of the quadrature step decoder: phase state machine, last
// event time, timeout register and report selection. Depends on qsd_pkg.
`default_nettype none

module qsd_core #(
    parameter int TIME_WIDTH = qsd_pkg::TIME_W_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [qsd_pkg::TIMEOUT_W-1:0] cfg_wr_data,
    input  wire logic                          step_en,
    input  wire qsd_pkg::in_item_t             item,
    output qsd_pkg::out_item_t                 result
);
    import qsd_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > TIMESTAMP_W) ? TIME_WIDTH : TIMESTAMP_W;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [TIME_WIDTH-1:0]   last_reg;
    logic [TIME_WIDTH-1:0]   last_next;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [CMP_W-1:0]        ts_ext;
    logic [TIME_WIDTH-1:0]   ts;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic                    timed_out;
    phase_t                  walk;
    report_t                 report;

    // Timestamp brought to the time width, elapsed time modulo 2^TIME_WIDTH
    assign ts_ext    = CMP_W'(item.timestamp);
    assign ts        = ts_ext[TIME_WIDTH-1:0];
    assign elapsed   = ts - last_reg;
    assign timed_out = CMP_W'(elapsed) >= CMP_W'(timeout_reg);
    assign walk      = next_phase(phase_reg, pins_t'(item.pins));

    // Next phase, next event time and report
    always_comb begin
        phase_next = phase_reg;
        last_next  = last_reg;
        report     = REP_NONE;
        if (item.kind == KIND_PIN) begin
            phase_next = walk;
            last_next  = ts;
            if (walk == PH_UNK && phase_reg != PH_UNK) begin
                report = REP_UNK;
            end else if (pins_t'(item.pins) == PIN_PP) begin
                case (phase_reg) inside
                    PH_C0, PH_D0: report = REP_CCW;
                    PH_C1, PH_D1: report = REP_CW;
                    default:      report = REP_NONE;
                endcase
            end
        end else if (phase_reg != PH_IDLE && timed_out) begin
            phase_next = PH_IDLE;
            last_next  = ts;
            report     = REP_CLEAR;
        end
    end

    // State registers advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            last_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    assign result.report = report;
    assign result.phase  = phase_next;

endmodule

`default_nettype wire

// ===== design/qsd_out_stage.sv =====
// Result register of the quadrature step decoder: holds one result until
// the consumer takes it. Depends on qsd_pkg.
`default_nettype none

module qsd_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire qsd_pkg::out_item_t load_data,
    output logic                    out_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output qsd_pkg::out_item_t      m_data
);
    import qsd_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;

    // Free when empty or being drained in this cycle
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/quadrature_step_decoder.sv =====
// Top level of the quadrature step decoder: input register, decode logic,
// result register. Depends on qsd_pkg, qsd_in_stage, qsd_core, qsd_out_stage.
//
//   port group              dir   handshake            payload
//   s_valid/s_ready/s_data  in    valid-ready          kind, pins, timestamp
//   m_valid/m_ready/m_data  out   valid-ready          report, phase
//   cfg_wr_en/cfg_wr_data   in    write enable only    timeout_ticks
//
// One request per cycle sustained while m_ready stays high; an accepted request
// passes the input register, then one decode pass into the result register,
// where it raises m_valid and is held until the consumer takes it.
// The phase and last event time update when a request moves into the result
// register. A stalled result holds m_data and backs up into the input register.
// Reset (aresetn low, synchronous) clears both stages, phase to idle,
// last event time to zero and the timeout to 1000.
`default_nettype none

module quadrature_step_decoder #(
    parameter int TIME_WIDTH = qsd_pkg::TIME_W_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire qsd_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output qsd_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [qsd_pkg::TIMEOUT_W-1:0] cfg_wr_data
);
    import qsd_pkg::*;

    logic      hold_valid;
    in_item_t  hold_data;
    logic      out_free;
    logic      advance;
    out_item_t result;

    // A held request moves on when the result register can take it
    assign advance = hold_valid && out_free;

    qsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    qsd_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (advance),
        .item        (hold_data),
        .result      (result)
    );

    qsd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (result),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // A step or clear always lands in idle
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.report == REP_CW || m_data.report == REP_CCW ||
                    m_data.report == REP_CLEAR) |-> m_data.phase == PH_IDLE)
        else $error("step or clear report without idle phase");

    // Entering unknown leaves the phase at unknown
    a_unk_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.report == REP_UNK |-> m_data.phase == PH_UNK)
        else $error("unknown report without unknown phase");

    // A request that leaves the input register shows up as a result
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("decoded request lost");

    // A held request that cannot advance keeps the input side stalled
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid && !out_free |-> !s_ready)
        else $error("input accepted while held request stalled");
`endif

endmodule

`default_nettype wire
